FILE: rtl/core/mmep_pkg.sv
// Shared constants, types and helpers for the min/max envelope pyramid.
// Used by every module under rtl/core; no dependencies of its own.
package mmep_pkg;

  localparam int unsigned LEVELS        = 6;
  localparam int unsigned CAPACITY_LOG2 = 32;
  localparam int unsigned SAMPLE_BITS   = 16;

  // Each level up spans 16x more samples: one nibble of the sample index.
  localparam int unsigned CellLog2   = 4;
  localparam int unsigned LvW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned CountW     = CAPACITY_LOG2 + 1;
  localparam int unsigned FifoDepth  = 2;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned FifoCntW   = $clog2(FifoDepth + 1);

  typedef enum logic {
    CmdAppend = 1'b0,
    CmdClear  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [CAPACITY_LOG2-1:0]      index;
    logic signed [SAMPLE_BITS-1:0] value;
  } entry_t;

  // Take the low SAMPLE_BITS bits of the raw field as a signed sample.
  function automatic logic signed [SAMPLE_BITS-1:0] take_sample(logic [15:0] raw);
    logic [SAMPLE_BITS+15:0] ext;
    ext = {{SAMPLE_BITS{1'b0}}, raw};
    return ext[SAMPLE_BITS-1:0];
  endfunction

  // Sign extend a sample and keep its low 16 bits for the result fields.
  function automatic logic [15:0] to_field(logic signed [SAMPLE_BITS-1:0] v);
    logic [SAMPLE_BITS+15:0] ext;
    ext = {{16{v[SAMPLE_BITS-1]}}, v};
    return ext[15:0];
  endfunction

endpackage

FILE: rtl/core/mmep_front.sv
// Front end: accepts transactions, tracks the sample count and capacity,
// and forwards appends to the queue. Depends on mmep_pkg.
module mmep_front import mmep_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          command_i,
  input  logic [15:0]   sample_value_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output entry_t        push_entry_o
);

  logic [CountW-1:0] count_q, count_d;
  logic              store_full_q, store_full_d;
  logic              accept, is_clear, at_cap;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign is_clear   = (cmd_e'(command_i) == CmdClear);
  assign at_cap     = count_q[CAPACITY_LOG2];

  assign push_valid_o       = accept && !is_clear && !at_cap;
  assign push_entry_o.index = count_q[CAPACITY_LOG2-1:0];
  assign push_entry_o.value = take_sample(sample_value_i);

  always_comb begin
    count_d      = count_q;
    store_full_d = store_full_q;
    if (accept) begin
      if (is_clear) begin
        count_d      = '0;
        store_full_d = 1'b0;
      end else if (at_cap) begin
        store_full_d = 1'b1;
      end else begin
        count_d = count_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      store_full_q <= 1'b0;
    end else begin
      count_q      <= count_d;
      store_full_q <= store_full_d;
    end
  end

  a_full_at_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_full_q |-> count_q[CAPACITY_LOG2])
    else $error("full flag set below capacity");

endmodule

FILE: rtl/core/mmep_fifo.sv
// Short queue between the front end and the level engine.
// Depends on mmep_pkg for the entry type and depth.
module mmep_fifo import mmep_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_valid_i,
  output logic   push_ready_o,
  input  entry_t push_entry_i,
  output logic   pop_valid_o,
  input  logic   pop_ready_i,
  output entry_t pop_entry_o
);

  entry_t              mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, rd_q;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign push_ready_o = (cnt_q != FifoCntW'(FifoDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_entry_o  = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + FifoCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= (wr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_q + FifoPtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_q + FifoPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_i |-> push_ready_o)
    else $error("push into full queue");

endmodule

FILE: rtl/core/mmep_back.sv
// Level engine: walks one queued sample through every pyramid level, one
// level per cycle unless the output stalls, into a registered output stage. Depends on mmep_pkg.
module mmep_back import mmep_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_valid_i,
  output logic        pop_ready_o,
  input  entry_t      pop_entry_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  level_o,
  output logic [27:0] cell_index_o,
  output logic [15:0] cell_min_o,
  output logic [15:0] cell_max_o,
  output logic        last_o
);

  logic signed [SAMPLE_BITS-1:0] lmin_q [LEVELS];
  logic signed [SAMPLE_BITS-1:0] lmax_q [LEVELS];

  logic                          busy_q;
  logic [LvW-1:0]                lv_q;
  logic [CAPACITY_LOG2-1:0]      cur_q;
  logic signed [SAMPLE_BITS-1:0] val_q;
  logic                          zrun_q;

  logic                          out_valid_q;
  logic [2:0]                    level_q;
  logic [27:0]                   cell_q;
  logic [15:0]                   min_q, max_q;
  logic                          last_q;

  logic                          advance, last_lv, load, restart;
  logic signed [SAMPLE_BITS-1:0] old_min, old_max, new_min, new_max;
  logic [CAPACITY_LOG2+27:0]     cell_ext;

  assign advance     = busy_q && (!out_valid_q || out_ready_i);
  assign last_lv     = (lv_q == LvW'(LEVELS - 1));
  assign pop_ready_o = !busy_q || (advance && last_lv);
  assign load        = pop_valid_i && pop_ready_o;

  // The cell restarts when every index nibble up to this level is zero.
  assign restart  = zrun_q && (cur_q[CellLog2-1:0] == '0);
  assign old_min  = lmin_q[lv_q];
  assign old_max  = lmax_q[lv_q];
  assign new_min  = (restart || (val_q < old_min)) ? val_q : old_min;
  assign new_max  = (restart || (val_q > old_max)) ? val_q : old_max;
  assign cell_ext = {28'b0, cur_q} >> CellLog2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      lv_q        <= '0;
      zrun_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        lv_q   <= '0;
        zrun_q <= 1'b1;
      end else if (advance) begin
        busy_q <= !last_lv;
        lv_q   <= lv_q + LvW'(1);
        zrun_q <= restart;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= pop_entry_i.index;
      val_q <= pop_entry_i.value;
    end else if (advance) begin
      cur_q <= cur_q >> CellLog2;
    end
    if (advance) begin
      lmin_q[lv_q] <= new_min;
      lmax_q[lv_q] <= new_max;
      level_q      <= 3'(lv_q);
      cell_q       <= cell_ext[27:0];
      min_q        <= to_field(new_min);
      max_q        <= to_field(new_max);
      last_q       <= last_lv;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign level_o      = level_q;
  assign cell_index_o = cell_q;
  assign cell_min_o   = min_q;
  assign cell_max_o   = max_q;
  assign last_o       = last_q;

  a_lv_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (lv_q <= LvW'(LEVELS - 1)))
    else $error("level counter out of range");

  a_stay_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !last_lv) |=> (busy_q && out_valid_q))
    else $error("sample dropped before its top level");

endmodule

FILE: rtl/core/min_max_envelope_pyramid.sv
// Min/max envelope pyramid: LEVELS results per appended sample, one per cycle
// unless the output stalls. An append goes through the queue and the level
// engine's sample registers into the registered output stage; last marks the
// top-level result. The single level engine takes the next sample as its top
// level goes out. Clear and dropped appends never enter the queue.
// Reset clears the sample count, full flag, queue and output stage.
module min_max_envelope_pyramid import mmep_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [15:0] sample_value_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  level_o,
  output logic [27:0] cell_index_o,
  output logic [15:0] cell_min_o,
  output logic [15:0] cell_max_o,
  output logic        last_o
);

  // Front to queue: an append transaction tagged with its sample index.
  logic   push_valid, push_ready;
  entry_t push_entry;
  // Queue to level engine.
  logic   pop_valid, pop_ready;
  entry_t pop_entry;

  // Classify each transaction: clear resets the count, appends past
  // capacity are dropped, the rest go into the queue with their index.
  mmep_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .command_i,
    .sample_value_i,
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  // Decouple the front from the level engine so each can stall on its own.
  mmep_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  // Update each level's running min/max and emit one result per level,
  // pulling the next sample as the top level goes out.
  mmep_back u_back (
    .clk_i,
    .rst_ni,
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_entry_i  (pop_entry),
    .out_valid_o,
    .out_ready_i,
    .level_o,
    .cell_index_o,
    .cell_min_o,
    .cell_max_o,
    .last_o
  );

endmodule
